// ===== hdl/ousl_pkg.sv =====
// Package for the ordered unique set table.
// Holds operation codes, the cell command struct and the control state type.
// No dependencies.
package ousl_pkg;

  localparam int ValueWidth = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_MEMBER = 3'd2,
    OP_FIRST  = 3'd3,
    OP_NEXT   = 3'd4
  } op_t;

  typedef struct packed {
    logic compare;
    logic insert;
    logic remove;
    logic read;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

// ===== hdl/ordered_unique_set_table_top.sv =====
// Ordered unique set table: a bounded set of distinct signed 32-bit values in
// insertion order with a read cursor. Input channel in_ (operation, value),
// result channel out_ (ok, read_value), both valid/stall. One result beat is
// returned for every input beat, in order.
// Each item has an accept cycle and an update cycle: in the accept cycle
// every cell compares its entry with the value and registers a match bit;
// in the update cycle (state ST_EXEC) the match position is reduced from
// those bits and the cell row inserts at the tail, shifts left from the
// match to remove, or presents a read entry. in_stall is high during the
// update cycle, so no new beat is taken until the last one's update is done.
// A result waits in an output register while out_stall is high; the next
// input beat is still taken, and its update cycle holds until the output
// register is free.
// Reset (rst_n low, synchronous) empties the table, sets the cursor to the
// first entry and drops any pending result. Entry contents are not cleared.
module ordered_unique_set_table_top
  import ousl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic signed [31:0] out_read_value
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  state_t                state_r, state_nxt;
  logic [2:0]            op_r;
  logic [ValueWidth-1:0] value_r;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         cursor_r, cursor_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [ValueWidth-1:0] out_rd_r, out_rd_nxt;

  logic                  in_fire, out_free, exec_fire;
  logic                  found;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         rd_idx;
  logic [ValueWidth-1:0] rd_data;
  cell_cmd_t             cmd;
  logic [ValueWidth-1:0] bus_value;

  logic [ValueWidth-1:0] cell_val [CAPACITY];
  logic [ValueWidth-1:0] right_val [CAPACITY];
  logic [ValueWidth-1:0] rd_part [CAPACITY];
  logic [CAPACITY-1:0]   hit;

  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r == ST_EXEC);
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_fire = (state_r == ST_EXEC) && out_free;
  assign bus_value = in_fire ? ValueWidth'(in_value) : value_r;
  assign rd_idx    = CW'(cursor_r + 1'b1);

  always_comb begin
    found = |hit;
    pos   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      pos = pos | (hit[i] ? CW'(i) : '0);
    end
  end

  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | rd_part[i];
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.compare = in_fire;
    if (exec_fire) begin
      case (op_r)
        OP_INSERT: cmd.insert = (count_r < CapCount) && !found;
        OP_REMOVE: cmd.remove = (count_r != '0) && found;
        OP_NEXT:   cmd.read   = (count_r != '0) && (cursor_r < count_r);
        default:   ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cursor_nxt    = cursor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ok_nxt    = out_ok_r;
    out_rd_nxt    = out_rd_r;
    if (in_fire) begin
      state_nxt = ST_EXEC;
    end
    if (exec_fire) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      out_ok_nxt    = 1'b0;
      out_rd_nxt    = '0;
      case (op_r)
        OP_INSERT: begin
          cursor_nxt = '0;
          if (cmd.insert) begin
            count_nxt  = CW'(count_r + 1'b1);
            out_ok_nxt = 1'b1;
          end
        end
        OP_REMOVE: begin
          if (count_r != '0) begin
            if (found) begin
              count_nxt  = CW'(count_r - 1'b1);
              cursor_nxt = '0;
              out_ok_nxt = 1'b1;
            end else begin
              cursor_nxt = count_r;
            end
          end
        end
        OP_MEMBER: begin
          cursor_nxt = '0;
          out_ok_nxt = found;
        end
        OP_FIRST: begin
          if (count_r != '0) begin
            cursor_nxt = '0;
            out_ok_nxt = 1'b1;
            out_rd_nxt = cell_val[0];
          end
        end
        OP_NEXT: begin
          if (count_r != '0) begin
            if (cursor_r < count_r) begin
              cursor_nxt = rd_idx;
              if (rd_idx < count_r) begin
                out_ok_nxt = 1'b1;
                out_rd_nxt = rd_data;
              end
            end else begin
              cursor_nxt = count_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r <= out_ok_nxt;
    out_rd_r <= out_rd_nxt;
    if (in_fire) begin
      op_r    <= in_operation;
      value_r <= ValueWidth'(in_value);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_last
      assign right_val[i] = '0;
    end else begin : g_mid
      assign right_val[i] = cell_val[i+1];
    end

    ousl_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .bus_value   (bus_value),
      .count       (count_r),
      .pos         (pos),
      .rd_idx      (rd_idx),
      .right_value (right_val[i]),
      .entry_value (cell_val[i]),
      .hit         (hit[i]),
      .rd_part     (rd_part[i])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = signed'(out_rd_r);

endmodule

// ===== hdl/ousl_cell.sv =====
// One storage cell of the set table: holds one entry and its match flag.
// Depends on ousl_pkg; takes its right neighbor's entry when the row shifts.
module ousl_cell
  import ousl_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_cmd_t             cmd,
  input  logic [ValueWidth-1:0] bus_value,
  input  logic [CW-1:0]         count,
  input  logic [CW-1:0]         pos,
  input  logic [CW-1:0]         rd_idx,
  input  logic [ValueWidth-1:0] right_value,
  output logic [ValueWidth-1:0] entry_value,
  output logic                  hit,
  output logic [ValueWidth-1:0] rd_part
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [ValueWidth-1:0] entry_r, entry_nxt;
  logic                  hit_r, hit_nxt;
  logic                  occupied;

  assign occupied = MyIdx < count;

  always_comb begin
    hit_nxt   = hit_r;
    entry_nxt = entry_r;
    if (cmd.compare) begin
      hit_nxt = occupied && (entry_r == bus_value);
    end
    if (cmd.insert && (MyIdx == count)) begin
      entry_nxt = bus_value;
    end
    if (cmd.remove && (MyIdx >= pos)) begin
      entry_nxt = right_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_value = entry_r;
  assign hit         = hit_r;
  assign rd_part     = (cmd.read && (MyIdx == rd_idx)) ? entry_r : '0;

endmodule

// ===== hdl/ousl_chk.sv =====
// Port-level checker for the ordered unique set table, bound to the top level.
// Depends only on the top level's ports.
module ousl_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_ok,
  input logic signed [31:0] out_read_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ok) && $stable(out_read_value))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken during update cycle");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> ##1 out_valid)
    else $error("result beat missing two cycles after input beat");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_read_value == 32'sd0)
    else $error("failed result carries nonzero read value");

endmodule

bind ordered_unique_set_table_top ousl_chk u_ousl_chk (.*);

// ===== test/tb_ordered_unique_set_table_top.sv =====
// Testbench for ordered_unique_set_table_top: drives operation beats from a queue and predicts
// each result with its own set model, checked in order on the result channel.
// Depends on ousl_pkg and the ordered_unique_set_table_top RTL.
module tb_ordered_unique_set_table_top;
  import ousl_pkg::*;

  localparam int CAPACITY = 16;
  localparam int NumUnusedOps = 3;
  localparam int PoolSize = 24;
  localparam int RandomItems = 1125;
  localparam int PhaseBeats = 150;
  localparam int HoldStart = 500;
  localparam int HoldCycles = 80;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 10;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] value;
  } op_beat_t;

  typedef struct {
    logic               ok;
    logic signed [31:0] read_value;
  } reply_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_operation = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_ok;
  logic signed [31:0] out_read_value;

  op_beat_t           op_beats[$];
  reply_t             set_replies[$];
  logic signed [31:0] value_pool[PoolSize];

  logic signed [31:0] set_entries[CAPACITY];
  int                 set_count = 0;
  int                 set_cursor = 0;

  int                 beats_taken = 0;
  int                 errors = 0;
  int                 idle_cycles = 0;
  int                 hold_left = 0;
  bit                 hold_done = 0;

  ordered_unique_set_table_top #(.CAPACITY(CAPACITY)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_read_value (out_read_value)
  );

  always #5 clk = ~clk;

  function automatic void apply_set_op(input logic [2:0] op, input logic signed [31:0] value,
                                       output logic ok, output logic signed [31:0] rd);
    int pos;
    int i;
    ok = 1'b0;
    rd = '0;
    pos = set_count;
    for (i = set_count - 1; i >= 0; i--) begin
      if (set_entries[i] == value) pos = i;
    end
    case (op)
      OP_INSERT: begin
        if (set_count < CAPACITY && pos == set_count) begin
          set_entries[set_count] = value;
          set_count++;
          ok = 1'b1;
        end
        set_cursor = 0;
      end
      OP_REMOVE: begin
        if (set_count != 0) begin
          if (pos < set_count) begin
            for (i = pos; i + 1 < set_count; i++) set_entries[i] = set_entries[i + 1];
            set_count--;
            ok = 1'b1;
            set_cursor = 0;
          end else begin
            set_cursor = set_count;
          end
        end
      end
      OP_MEMBER: begin
        ok = (pos < set_count);
        set_cursor = 0;
      end
      OP_FIRST: begin
        if (set_count != 0) begin
          set_cursor = 0;
          rd = set_entries[0];
          ok = 1'b1;
        end
      end
      OP_NEXT: begin
        if (set_count != 0) begin
          if (set_cursor < set_count) begin
            set_cursor++;
            if (set_cursor < set_count) begin
              rd = set_entries[set_cursor];
              ok = 1'b1;
            end
          end else begin
            set_cursor = set_count;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic push_op(input logic [2:0] op, input logic signed [31:0] value);
    op_beat_t b;
    b.op = op;
    b.value = value;
    op_beats.push_back(b);
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(9) == 0) return $urandom();
    return value_pool[$urandom_range(PoolSize - 1)];
  endfunction

  function automatic logic [2:0] unused_op();
    return 3'(int'(OP_NEXT) + 1 + $urandom_range(NumUnusedOps - 1));
  endfunction

  function automatic int current_phase();
    return (beats_taken / PhaseBeats) % 4;
  endfunction

  // driver: hold a stalled beat, otherwise offer the next one or idle
  always @(posedge clk) begin
    logic               ok;
    logic signed [31:0] rd;
    int                 idle_pct;
    op_beat_t           b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_set_op(in_operation, in_value, ok, rd);
        set_replies.push_back('{ok: ok, read_value: rd});
        beats_taken++;
      end
      case (current_phase())
        1: idle_pct = 46;
        3: idle_pct = 37;
        default: idle_pct = 0;
      endcase
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (op_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
        b = op_beats.pop_front();
        in_valid <= 1'b1;
        in_operation <= b.op;
        in_value <= b.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall per phase, one long hold to back up the block
  always @(posedge clk) begin
    int stall_pct;
    case (current_phase())
      2: stall_pct = 46;
      3: stall_pct = 37;
      default: stall_pct = 0;
    endcase
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && beats_taken >= HoldStart) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk) begin
    reply_t r;
    if (rst_n && out_valid && !out_stall) begin
      if (set_replies.size() == 0) begin
        $error("unexpected result beat: ok %0d read_value %0d", out_ok, out_read_value);
        errors++;
      end else begin
        r = set_replies.pop_front();
        if (out_ok !== r.ok) begin
          $error("ok mismatch: expected %0d, actual %0d", r.ok, out_ok);
          errors++;
        end
        if (out_read_value !== r.read_value) begin
          $error("read_value mismatch: expected %0d, actual %0d", r.read_value,
                 out_read_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb_ordered_unique_set_table_top failed");
      $finish;
    end
  end

  initial begin
    int k;
    int n;
    int kind;
    int random_count;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (k = 4; k < PoolSize; k++) value_pool[k] = $urandom();

    push_op(OP_FIRST, $urandom());
    push_op(OP_NEXT, $urandom());
    push_op(OP_REMOVE, 32'sd5);
    push_op(OP_INSERT, 32'sh8000_0000);
    push_op(OP_INSERT, 32'sh7fff_ffff);
    push_op(OP_INSERT, '0);
    push_op(OP_INSERT, -32'sd1);
    push_op(OP_INSERT, 32'sh7fff_ffff);
    push_op(OP_MEMBER, 32'sh8000_0000);
    push_op(OP_MEMBER, 32'sd12345);
    push_op(OP_FIRST, '0);
    push_op(OP_NEXT, '0);
    push_op(OP_NEXT, '0);
    push_op(OP_NEXT, '0);
    push_op(OP_NEXT, '0);
    push_op(OP_REMOVE, 32'sd77);
    push_op(OP_NEXT, '0);
    push_op(OP_REMOVE, 32'sh7fff_ffff);
    push_op(OP_FIRST, -32'sd1);
    push_op(OP_NEXT, -32'sd1);
    for (k = 1; k <= NumUnusedOps; k++) push_op(3'(int'(OP_NEXT) + k), -32'sd1);
    push_op(OP_REMOVE, 32'sh8000_0000);
    push_op(OP_MEMBER, '0);

    random_count = 0;
    while (random_count < RandomItems) begin
      kind = $urandom_range(99);
      if (kind < 30) begin
        n = $urandom_range(4, 20);
        for (k = 0; k < n; k++) push_op(OP_INSERT, pick_value());
      end else if (kind < 50) begin
        n = $urandom_range(1, 18);
        push_op(OP_FIRST, $urandom());
        for (k = 0; k < n; k++) push_op(OP_NEXT, $urandom());
        n++;
      end else if (kind < 70) begin
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) push_op(OP_REMOVE, pick_value());
      end else if (kind < 90) begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) push_op(OP_MEMBER, pick_value());
      end else begin
        n = 1;
        if ($urandom_range(3) == 0) push_op(unused_op(), $urandom());
        else push_op(3'($urandom_range(int'(OP_NEXT))), $urandom());
      end
      random_count += n;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (op_beats.size() == 0 && !in_valid);
    wait (set_replies.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && set_replies.size() == 0) begin
      $display("tb_ordered_unique_set_table_top passed");
    end else begin
      $display("tb_ordered_unique_set_table_top failed");
    end
    $finish;
  end

endmodule
